FILE: sv/wsp_pkg.sv
// Package for the WAV stream parser: payload structs, phase codes, tags.
// No dependencies.
`default_nettype none
package wsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } wsp_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               error_code;
    logic [15:0]        audio_format;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [31:0]        byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        sample_bits;
    logic [31:0]        sample_count;
    logic signed [15:0] sample_value;
    logic               last_sample;
  } wsp_out_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic ERR_RIFF = 1'b0;
  localparam logic ERR_WAVE = 1'b1;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [31:0] FMT_BASE_SIZE = 32'd16;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_FSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_FTAG  = 4'd3;
  localparam logic [3:0] PH_FSKSZ = 4'd4;
  localparam logic [3:0] PH_FSKIP = 4'd5;
  localparam logic [3:0] PH_FMTSZ = 4'd6;
  localparam logic [3:0] PH_FMT   = 4'd7;
  localparam logic [3:0] PH_FMTX  = 4'd8;
  localparam logic [3:0] PH_DTAG  = 4'd9;
  localparam logic [3:0] PH_DSKSZ = 4'd10;
  localparam logic [3:0] PH_DSKIP = 4'd11;
  localparam logic [3:0] PH_DSIZE = 4'd12;
  localparam logic [3:0] PH_SAMP  = 4'd13;
  localparam logic [3:0] PH_HALT  = 4'd14;
  localparam logic [3:0] PH_DIV   = 4'd15;

  // controller -> datapath
  typedef struct packed {
    logic       take;
    logic       restart;
    logic       load_skip;
    logic       load_extra;
    logic       dec_count;
    logic       fmt_byte;
    logic       size_load;
    logic       div_start;
    logic       low_byte;
    logic       out_header;
    logic       out_sample;
    logic       out_error;
    logic       err_code;
    logic       clr_count;
  } wsp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic word_done;
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic tag_data;
    logic skip_zero;
    logic extra_zero;
    logic count_one;
    logic fmt_done;
    logic div_busy;
    logic bits16;
    logic bits_ok;
    logic half_full;
    logic last;
  } wsp_sts_t;

endpackage
`default_nettype wire

FILE: sv/wsp_datapath.sv
// Datapath of the WAV stream parser: shift registers, fmt fields, counters,
// a bit-serial divider for the sample count and the output register. Uses wsp_pkg.
`default_nettype none
module wsp_datapath (
  input  wire               clk,
  input  wire               rst_n,
  input  wire [7:0]         data_byte,
  input  wsp_pkg::wsp_cmd_t cmd,
  input  wire               out_ready,
  output wsp_pkg::wsp_sts_t sts,
  output logic              out_valid,
  output wsp_pkg::wsp_out_t out_data
);
  import wsp_pkg::*;

  logic [31:0] tag_r, acc_r, cnt_r, fsize_r, left_r;
  logic [15:0] ftag_r, chan_r, align_r, bits_r;
  logic [31:0] srate_r, brate_r;
  logic [7:0]  low_r;
  logic [31:0] quo_r, rem_r, dsor_r;
  logic [5:0]  div_cnt_r;
  logic        div_busy_r;
  logic        out_valid_r;
  wsp_out_t    out_r;

  logic [31:0] acc_nxt, tag_nxt, cnt_inc, cnt_nxt;
  logic [32:0] rem_sh;
  logic [31:0] left_dec;

  assign acc_nxt  = {data_byte, acc_r[31:8]};
  assign tag_nxt  = {tag_r[23:0], data_byte};
  assign cnt_inc  = cnt_r + 32'd1;
  assign rem_sh   = {rem_r, quo_r[31]};
  assign left_dec = left_r - 32'd1;

  assign sts.word_done  = (cnt_r[1:0] == 2'd3);
  assign sts.tag_riff   = (tag_nxt == TAG_RIFF);
  assign sts.tag_wave   = (tag_nxt == TAG_WAVE);
  assign sts.tag_fmt    = (tag_nxt == TAG_FMT);
  assign sts.tag_data   = (tag_nxt == TAG_DATA);
  assign sts.skip_zero  = (acc_nxt == 32'd0);
  assign sts.extra_zero = (fsize_r <= FMT_BASE_SIZE);
  assign sts.count_one  = (cnt_r == 32'd1);
  assign sts.fmt_done   = (cnt_r[3:0] == 4'd15);
  assign sts.div_busy   = div_busy_r;
  assign sts.bits16     = (bits_r == 16'd16);
  assign sts.bits_ok    = (bits_r == 16'd16 || bits_r == 16'd8) && quo_r != 32'd0;
  assign sts.half_full  = cnt_r[0];
  assign sts.last       = (left_r == 32'd1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.take) begin
      if (cmd.restart) cnt_nxt = 32'd1;
      else cnt_nxt = sts.word_done ? 32'd0 : cnt_inc;
    end
    if (cmd.load_skip) cnt_nxt = acc_nxt;
    if (cmd.load_extra) cnt_nxt = sts.extra_zero ? 32'd0 : fsize_r - FMT_BASE_SIZE;
    else if (cmd.fmt_byte) cnt_nxt = cnt_inc;
    if (cmd.dec_count) cnt_nxt = cnt_r - 32'd1;
    if (cmd.clr_count) cnt_nxt = '0;
    if (cmd.low_byte) cnt_nxt = 32'd1;
    if (cmd.out_sample) cnt_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tag_r <= '0;
      acc_r <= '0;
      div_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.out_header || cmd.out_sample || cmd.out_error) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.restart) begin
        ftag_r <= '0; chan_r <= '0; srate_r <= '0; brate_r <= '0;
        align_r <= '0; bits_r <= '0; fsize_r <= '0;
      end
      if (cmd.take) begin
        tag_r <= cmd.restart ? {24'd0, data_byte} : tag_nxt;
        acc_r <= cmd.restart ? {data_byte, 24'd0} : acc_nxt;
      end
      if (cmd.size_load) fsize_r <= acc_nxt;
      if (cmd.fmt_byte) begin
        acc_r <= acc_nxt;
        case (cnt_r[3:0])
          4'd1:    ftag_r  <= acc_nxt[31:16];
          4'd3:    chan_r  <= acc_nxt[31:16];
          4'd7:    srate_r <= acc_nxt;
          4'd11:   brate_r <= acc_nxt;
          4'd13:   align_r <= acc_nxt[31:16];
          4'd15:   bits_r  <= acc_nxt[31:16];
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        quo_r <= (bits_r[15:3] == 13'd0) ? 32'd0 : acc_nxt;
        rem_r <= '0;
        dsor_r <= {19'd0, bits_r[15:3]};
        div_cnt_r <= 6'd32;
        div_busy_r <= (bits_r[15:3] != 13'd0);
      end else if (div_busy_r) begin
        if (rem_sh >= {1'b0, dsor_r}) begin
          rem_r <= 32'(rem_sh - {1'b0, dsor_r});
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) div_busy_r <= 1'b0;
      end
      if (cmd.low_byte) low_r <= data_byte;
      if (cmd.out_header) begin
        left_r <= quo_r;
        out_r <= '{result_kind: KIND_HEADER, audio_format: ftag_r, channel_count: chan_r,
                   sample_rate: srate_r, byte_rate: brate_r, block_align: align_r,
                   sample_bits: bits_r, sample_count: quo_r, default: '0};
      end
      if (cmd.out_sample) begin
        left_r <= left_dec;
        out_r <= '{result_kind: KIND_SAMPLE,
                   sample_value: sts.bits16 ? {data_byte, low_r} : {8'd0, data_byte},
                   last_sample: sts.last, default: '0};
      end
      if (cmd.out_error) begin
        out_r <= '{result_kind: KIND_ERROR, error_code: cmd.err_code, default: '0};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

FILE: sv/wsp_ctrl.sv
// Controller of the WAV stream parser: parse phase machine and input handshake.
// Uses wsp_pkg; drives wsp_datapath through wsp_cmd_t.
`default_nettype none
module wsp_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               first_byte,
  input  wire               out_busy,
  input  wsp_pkg::wsp_sts_t sts,
  output logic              in_ready,
  output wsp_pkg::wsp_cmd_t cmd
);
  import wsp_pkg::*;

  logic [3:0] ph_r, ph_nxt, ph_eff;
  logic       go;

  assign in_ready = (ph_r != PH_DIV) && !out_busy;
  assign go = in_valid && in_ready;
  assign ph_eff = first_byte ? PH_RIFF : ph_r;

  always_comb begin
    cmd = '0;
    ph_nxt = ph_r;
    if (ph_r == PH_DIV) begin
      if (!sts.div_busy && !out_busy) begin
        cmd.out_header = 1'b1;
        cmd.clr_count = 1'b1;
        ph_nxt = sts.bits_ok ? PH_SAMP : PH_HALT;
      end
    end else if (go) begin
      cmd.restart = first_byte;
      case (ph_eff)
        PH_RIFF: begin
          cmd.take = 1'b1;
          if (sts.word_done && !first_byte) begin
            if (!sts.tag_riff) begin
              cmd.out_error = 1'b1;
              cmd.err_code = ERR_RIFF;
              ph_nxt = PH_HALT;
            end else ph_nxt = PH_FSIZE;
          end else ph_nxt = PH_RIFF;
        end
        PH_FSIZE: begin
          cmd.take = 1'b1;
          if (sts.word_done) ph_nxt = PH_WAVE;
        end
        PH_WAVE: begin
          cmd.take = 1'b1;
          if (sts.word_done) begin
            if (!sts.tag_wave) begin
              cmd.out_error = 1'b1;
              cmd.err_code = ERR_WAVE;
              ph_nxt = PH_HALT;
            end else ph_nxt = PH_FTAG;
          end
        end
        PH_FTAG, PH_DTAG: begin
          cmd.take = 1'b1;
          if (sts.word_done) begin
            if (ph_eff == PH_FTAG) ph_nxt = sts.tag_fmt ? PH_FMTSZ : PH_FSKSZ;
            else ph_nxt = sts.tag_data ? PH_DSIZE : PH_DSKSZ;
          end
        end
        PH_FSKSZ, PH_DSKSZ: begin
          cmd.take = 1'b1;
          if (sts.word_done) begin
            cmd.load_skip = 1'b1;
            if (sts.skip_zero) ph_nxt = (ph_eff == PH_FSKSZ) ? PH_FTAG : PH_DTAG;
            else ph_nxt = (ph_eff == PH_FSKSZ) ? PH_FSKIP : PH_DSKIP;
          end
        end
        PH_FSKIP, PH_FMTX, PH_DSKIP: begin
          cmd.dec_count = 1'b1;
          if (sts.count_one) ph_nxt = (ph_eff == PH_FSKIP) ? PH_FTAG : PH_DTAG;
        end
        PH_FMTSZ: begin
          cmd.take = 1'b1;
          if (sts.word_done) begin
            cmd.size_load = 1'b1;
            ph_nxt = PH_FMT;
          end
        end
        PH_FMT: begin
          cmd.fmt_byte = 1'b1;
          if (sts.fmt_done) begin
            cmd.load_extra = 1'b1;
            ph_nxt = sts.extra_zero ? PH_DTAG : PH_FMTX;
          end
        end
        PH_DSIZE: begin
          cmd.take = 1'b1;
          if (sts.word_done) begin
            cmd.div_start = 1'b1;
            ph_nxt = PH_DIV;
          end
        end
        PH_SAMP: begin
          if (sts.bits16 && !sts.half_full) cmd.low_byte = 1'b1;
          else begin
            cmd.out_sample = 1'b1;
            if (sts.last) ph_nxt = PH_HALT;
          end
        end
        default: ph_nxt = ph_eff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= PH_RIFF;
    else ph_r <= ph_nxt;
  end
endmodule
`default_nettype wire

FILE: sv/wav_stream_parser.sv
// Top level of the WAV stream parser: controller plus datapath.
// Uses wsp_pkg, wsp_ctrl and wsp_datapath.
`default_nettype none
// One byte is taken per cycle unless a result waits in the output register.
// After the data size is read, a bit-serial divider computes the sample
// count; no byte is taken while it runs, nor in the cycle that loads the
// header result.
module wav_stream_parser (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wsp_pkg::wsp_in_t  in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output wsp_pkg::wsp_out_t out_data
);
  import wsp_pkg::*;

  wsp_cmd_t cmd;
  wsp_sts_t sts;
  logic     busy;

  assign busy = out_valid && !out_ready;

  wsp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .first_byte(in_data.first_byte),
    .out_busy(busy), .sts(sts), .in_ready(in_ready), .cmd(cmd)
  );

  wsp_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .data_byte(in_data.data_byte), .cmd(cmd),
    .out_ready(out_ready), .sts(sts), .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire

FILE: sv/wsp_checker.sv
// Port checker for wav_stream_parser, bound to the top level.
// Uses wsp_pkg.
`default_nettype none
module wsp_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input wsp_pkg::wsp_out_t out_data
);
  import wsp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.result_kind != 2'd3)
    else $error("bad result kind");
  a_no_take_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("byte taken while result stalled");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_sample |-> out_data.result_kind == KIND_SAMPLE)
    else $error("last flag on non-sample");
endmodule

bind wav_stream_parser wsp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

FILE: dv/wav_stream_parser_tb.sv
// Testbench for wav_stream_parser: streams WAV files byte by byte and checks
// header, sample and error results against an in-bench parser model.
// Depends on wsp_pkg and the wav_stream_parser RTL.
`timescale 1ns / 1ps
module wav_stream_parser_tb;
  import wsp_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  wsp_in_t in_data;
  logic out_valid;
  logic out_ready;
  wsp_out_t out_data;

  wav_stream_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // parser model state
  logic [3:0]  m_phase;
  logic [31:0] m_count, m_tag, m_acc;
  logic [15:0] m_fmt_tag, m_chans, m_align, m_bits;
  logic [31:0] m_rate, m_brate, m_fmt_len, m_left;
  logic [7:0]  m_low;

  wsp_out_t expected_q[$];
  int       errors;
  int       mismatches;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       hold_cycles;
  longint   cycle_count;
  byte      file_q[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic add_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endtask

  task automatic add_expect(wsp_out_t r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic model_reset();
    m_phase = PH_RIFF; m_count = 0; m_tag = 0; m_acc = 0;
    m_fmt_tag = 0; m_chans = 0; m_align = 0; m_bits = 0;
    m_rate = 0; m_brate = 0; m_fmt_len = 0; m_left = 0; m_low = 0;
  endtask

  function automatic bit take_word(logic [7:0] b);
    m_tag = {m_tag[23:0], b};
    m_acc = {b, m_acc[31:8]};
    m_count++;
    if (m_count >= 4) begin
      m_count = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic begin_skip(logic [31:0] n, logic [3:0] skip_ph, logic [3:0] next_ph);
    m_count = n;
    m_phase = (n == 0) ? next_ph : skip_ph;
  endtask

  task automatic parse_byte(logic [7:0] b, logic first);
    wsp_out_t r;
    logic [31:0] div;
    logic [31:0] extra;
    r = '0;
    if (first) model_reset();
    case (m_phase)
      PH_RIFF: if (take_word(b)) begin
        if (m_tag != TAG_RIFF) begin
          r.result_kind = KIND_ERROR; r.error_code = ERR_RIFF;
          m_phase = PH_HALT; add_expect(r);
        end else m_phase = PH_FSIZE;
      end
      PH_FSIZE: if (take_word(b)) m_phase = PH_WAVE;
      PH_WAVE: if (take_word(b)) begin
        if (m_tag != TAG_WAVE) begin
          r.result_kind = KIND_ERROR; r.error_code = ERR_WAVE;
          m_phase = PH_HALT; add_expect(r);
        end else m_phase = PH_FTAG;
      end
      PH_FTAG: if (take_word(b)) m_phase = (m_tag == TAG_FMT) ? PH_FMTSZ : PH_FSKSZ;
      PH_FSKSZ: if (take_word(b)) begin_skip(m_acc, PH_FSKIP, PH_FTAG);
      PH_FSKIP, PH_FMTX, PH_DSKIP: begin
        m_count--;
        if (m_count == 0) m_phase = (m_phase == PH_FSKIP) ? PH_FTAG : PH_DTAG;
      end
      PH_FMTSZ: if (take_word(b)) begin
        m_fmt_len = m_acc; m_phase = PH_FMT;
      end
      PH_FMT: begin
        m_acc = {b, m_acc[31:8]};
        case (m_count)
          1: m_fmt_tag = m_acc[31:16];
          3: m_chans = m_acc[31:16];
          7: m_rate = m_acc;
          11: m_brate = m_acc;
          13: m_align = m_acc[31:16];
          15: m_bits = m_acc[31:16];
          default: ;
        endcase
        m_count++;
        if (m_count >= FMT_BASE_SIZE) begin
          extra = (m_fmt_len > FMT_BASE_SIZE) ? m_fmt_len - FMT_BASE_SIZE : 0;
          begin_skip(extra, PH_FMTX, PH_DTAG);
        end
      end
      PH_DTAG: if (take_word(b)) m_phase = (m_tag == TAG_DATA) ? PH_DSIZE : PH_DSKSZ;
      PH_DSKSZ: if (take_word(b)) begin_skip(m_acc, PH_DSKIP, PH_DTAG);
      PH_DSIZE: if (take_word(b)) begin
        div = {19'd0, m_bits[15:3]};
        m_left = (div == 0) ? 0 : m_acc / div;
        r.result_kind = KIND_HEADER;
        r.audio_format = m_fmt_tag; r.channel_count = m_chans;
        r.sample_rate = m_rate; r.byte_rate = m_brate;
        r.block_align = m_align; r.sample_bits = m_bits;
        r.sample_count = m_left;
        m_count = 0;
        m_phase = (m_left != 0 && (m_bits == 16 || m_bits == 8)) ? PH_SAMP : PH_HALT;
        add_expect(r);
      end
      PH_SAMP: begin
        if (m_bits == 16 && m_count == 0) begin
          m_low = b; m_count = 1;
        end else begin
          r.result_kind = KIND_SAMPLE;
          if (m_bits == 16) begin
            r.sample_value = {b, m_low}; m_count = 0;
          end else r.sample_value = {8'd0, b};
          m_left--;
          if (m_left == 0) begin
            r.last_sample = 1'b1; m_phase = PH_HALT;
          end
          add_expect(r);
        end
      end
      default: ;
    endcase
  endtask

  // drive one byte, hold until transfer
  task automatic send_byte(logic [7:0] b, logic first);
    while (($urandom % 100) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, first_byte: first};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b, first);
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == 0);
    file_q.delete();
  endtask

  task automatic push_word(logic [31:0] w);
    add_byte(w[7:0]); add_byte(w[15:8]);
    add_byte(w[23:16]); add_byte(w[31:24]);
  endtask

  task automatic push_tag(logic [31:0] t);
    add_byte(t[31:24]); add_byte(t[23:16]);
    add_byte(t[15:8]); add_byte(t[7:0]);
  endtask

  task automatic push_half(logic [15:0] h);
    add_byte(h[7:0]); add_byte(h[15:8]);
  endtask

  // build a WAV file with random data bytes and optional junk chunks
  task automatic build_wav(logic [15:0] bits, int fmt_len, int junk_before_fmt,
                           int junk_before_data, int data_bytes, bit rnd_fields);
    int i;
    push_tag(TAG_RIFF);
    push_word($urandom);
    push_tag(TAG_WAVE);
    if (junk_before_fmt >= 0) begin
      push_tag($urandom | 32'h0100_0000);
      push_word(32'(junk_before_fmt));
      for (i = 0; i < junk_before_fmt; i++) add_byte(8'($urandom));
    end
    push_tag(TAG_FMT);
    push_word(32'(fmt_len));
    push_half(rnd_fields ? 16'($urandom) : 16'd1);
    push_half(rnd_fields ? 16'($urandom) : 16'd2);
    push_word(rnd_fields ? $urandom : 32'd48000);
    push_word(rnd_fields ? $urandom : 32'hFFFF_FFFF);
    push_half(rnd_fields ? 16'($urandom) : 16'hFFFF);
    push_half(bits);
    for (i = 16; i < fmt_len; i++) add_byte(8'($urandom));
    if (junk_before_data >= 0) begin
      push_tag(32'h4C495354);
      push_word(32'(junk_before_data));
      for (i = 0; i < junk_before_data; i++) add_byte(8'($urandom));
    end
    push_tag(TAG_DATA);
    push_word(32'(data_bytes));
    for (i = 0; i < data_bytes; i++) add_byte(8'($urandom));
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %h", out_data);
        end else if (expected_q[0] != out_data) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected %h actual %h", expected_q[0], out_data);
          void'(expected_q.pop_front());
        end else void'(expected_q.pop_front());
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else out_ready <= (($urandom % 100) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 100000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic test_directed();
    // extremes of fmt fields, 16-bit with junk chunks and extended fmt
    build_wav(16'd16, 18, 3, 0, 8, 1'b0); send_file();
    build_wav(16'd8, 16, -1, -1, 5, 1'b1); send_file();
    // bit depth below 8, unsupported 24-bit depth, zero count, short fmt size
    build_wav(16'd4, 16, -1, -1, 4, 1'b1); send_file();
    build_wav(16'd24, 16, -1, -1, 6, 1'b1); send_file();
    build_wav(16'd16, 16, -1, -1, 0, 1'b1); send_file();
    build_wav(16'd8, 2, -1, -1, 3, 1'b1); send_file();
    // bad RIFF tag, bad WAVE tag, bytes after halt
    push_tag(32'h52494647); push_word(0); send_file();
    push_tag(TAG_RIFF); push_word(0); push_tag(32'h57415646); push_word(7); send_file();
    // truncated then restart
    push_tag(TAG_RIFF); push_word(1); send_file();
  endtask

  task automatic test_random(int n_items);
    int sent;
    int k;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(0, 9);
      if (k < 7)
        build_wav(($urandom_range(0, 3) == 0) ? 16'($urandom) :
                  (($urandom_range(0, 1) != 0) ? 16'd16 : 16'd8),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : 16,
                  $urandom_range(0, 1) != 0 ? $urandom_range(0, 4) : -1,
                  $urandom_range(0, 1) != 0 ? $urandom_range(0, 4) : -1,
                  $urandom_range(0, 24), 1'b1);
      else
        for (k = 0; k < $urandom_range(1, 30); k++) add_byte(8'($urandom));
      if ($urandom_range(0, 4) == 0 && file_q.size() > 12)
        file_q[$urandom_range(0, 11)] = 8'($urandom);
      sent += file_q.size();
      send_file();
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    build_wav(16'd8, 16, -1, -1, 24, 1'b1);
    send_file();
  endtask

  initial begin : main
    errors = 0; mismatches = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 26; recv_idle_pct = 67;
    test_directed();
    send_idle_pct = 67; recv_idle_pct = 26;
    test_random(50);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

FILE: wav_stream_parser.f
sv/wsp_pkg.sv
sv/wsp_datapath.sv
sv/wsp_ctrl.sv
sv/wav_stream_parser.sv
sv/wsp_checker.sv
dv/wav_stream_parser_tb.sv
